### src/assert_macros.svh
// Assertion macros of the allocator, included by bra_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define BRA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Implication checked on every rising clock edge outside reset.
`define BRA_ASSERT_IMP(name, clk, rst_n, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

`endif

### src/bra_pkg.sv
// Types and constants of the bitmap range allocator.
package bra_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 64;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_TOTAL = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [CNT_W-1:0]  count;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] address;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [SIZE_W-1:0] item_size;
    logic [CNT_W-1:0]  map_items;
  } cfg_t;

  typedef enum logic [1:0] {
    RES_FAIL = 2'd0,
    RES_BASE = 2'd1,
    RES_ZERO = 2'd2,
    RES_ADDR = 2'd3
  } res_kind_e;

  typedef struct packed {
    logic      load;
    logic      div_start;
    logic      scan_step;
    logic      free_setup;
    logic      mark_step;
    logic      mul;
    logic      res_load;
    res_kind_e res_kind;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic total_zero;
    logic count_zero;
    logic below_base;
    logic div_done;
    logic q_past_end;
    logic scan_hit;
    logic scan_last;
    logic mark_last;
    logic out_free;
  } sts_t;

endpackage

### src/bitmap_range_allocator_top.sv
// Allocate: the scan finds a free run, its bitmap words are marked, then the address is multiplied out.
// Free: the offset goes through the 64-step one-bit-per-cycle divider, then the run's words are cleared.
// The scan walks one bitmap bit per cycle; one request is in work at a time.
// A finished result waits in the output register while the next item is taken.
// Reset (async, active low) frees all items and sets base 0, item size 1, map size 0.
module bitmap_range_allocator_top import bra_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 1024,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  req_t               in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rsp_t               out_rsp_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_sel;
  cmd_t       cmd;
  sts_t       sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{base_address: '0, item_size: SIZE_W'(1), map_items: '0};
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BASE:  cfg_q.base_address <= pwdata;
        REG_SIZE:  cfg_q.item_size    <= pwdata[SIZE_W-1:0];
        REG_TOTAL: cfg_q.map_items    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BASE:  prdata = cfg_q.base_address;
      REG_SIZE:  prdata = PDATA_W'(cfg_q.item_size);
      REG_TOTAL: prdata = PDATA_W'(cfg_q.map_items);
      default:   prdata = '0;
    endcase
  end

  bra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bra_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clear_map_i (wr_en && (reg_sel == REG_TOTAL)),
    .in_req_i    (in_req_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

### src/bra_div.sv
// Restoring divider, one quotient bit per cycle.
module bra_div import bra_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ADDR_W-1:0] dividend_i,
  input  logic [SIZE_W-1:0] divisor_i,
  output logic              done_o,
  output logic [ADDR_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(ADDR_W + 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [ADDR_W-1:0] quo_q, quo_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W:0]   trial;
  logic              fin;

  assign fin    = busy_q && (cnt_q == STEP_W'(ADDR_W));
  assign trial  = {rem_q, quo_q[ADDR_W-1]};
  assign done_o = fin;
  assign quotient_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (fin) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = SIZE_W'(trial - {1'b0, divisor_i});
        quo_d = {quo_q[ADDR_W-2:0], 1'b1};
      end else begin
        rem_d = trial[SIZE_W-1:0];
        quo_d = {quo_q[ADDR_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

endmodule

### src/bra_datapath.sv
// Bitmap store, scan and mark logic, address math and result register.
module bra_datapath import bra_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 1024,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic clear_map_i,
  input  req_t in_req_i,
  input  logic out_ready_i,
  output logic out_valid_o,
  output rsp_t out_rsp_o,
  input  cmd_t cmd_i,
  output sts_t sts_o
);

  localparam int unsigned MAP_WORDS = (MAX_ITEMS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned IW = $clog2(MAX_ITEMS);
  localparam int unsigned TW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned PW = IW + SIZE_W;

  logic [WORD_BITS-1:0] mem_q [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;

  req_t          req_q;
  logic [TW-1:0] i_q, run_q;
  logic [IW-1:0] start_q, last_q;
  logic [AW-1:0] w_q;
  logic [PW-1:0] prod_q;
  logic          out_valid_q;
  rsp_t          rsp_q;

  logic [31:0]          tot32;
  logic [TW-1:0]        total;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_word, mask, new_word;
  logic                 cur_bit;
  logic [AW-1:0]        ws, we;
  logic [BW-1:0]        lo, hi;
  logic [ADDR_W-1:0]    quo;
  logic                 div_done;
  logic [SIZE_W-1:0]    divisor;
  logic [31:0]          q32, e32;
  logic [IW-1:0]        hit_start, set_start, set_last;

  assign tot32 = (32'(cfg_i.map_items) > 32'(MAX_ITEMS)) ? 32'(MAX_ITEMS)
                                                         : 32'(cfg_i.map_items);
  assign total = tot32[TW-1:0];

  assign rd_addr = cmd_i.mark_step ? w_q : AW'(i_q / WORD_BITS);
  assign rd_word = vld_q[rd_addr] ? mem_q[rd_addr] : '0;
  assign cur_bit = rd_word[BW'(i_q % WORD_BITS)];

  assign divisor = (cfg_i.item_size == '0) ? SIZE_W'(1) : cfg_i.item_size;

  bra_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (req_q.free_address - cfg_i.base_address),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Free run end, clamped to the managed items
  always_comb begin
    q32 = quo[31:0];
    e32 = q32 + 32'(req_q.count);
    if (e32 > tot32) begin
      e32 = tot32;
    end
  end

  assign hit_start = IW'(32'(i_q) + 32'd1 - 32'(req_q.count));
  assign set_start = cmd_i.free_setup ? IW'(q32) : hit_start;
  assign set_last  = cmd_i.free_setup ? IW'(e32 - 32'd1) : IW'(i_q);

  assign ws = AW'(start_q / WORD_BITS);
  assign we = AW'(last_q / WORD_BITS);
  assign lo = (w_q == ws) ? BW'(start_q % WORD_BITS) : '0;
  assign hi = (w_q == we) ? BW'(last_q % WORD_BITS) : BW'(WORD_BITS - 1);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (32'(b) >= 32'(lo)) && (32'(b) <= 32'(hi));
    end
    new_word = (req_q.func == FUNC_FREE) ? (rd_word & ~mask) : (rd_word | mask);
  end

  always_comb begin
    sts_o.is_free    = (req_q.func == FUNC_FREE);
    sts_o.total_zero = (total == '0);
    sts_o.count_zero = (req_q.count == '0);
    sts_o.below_base = (req_q.free_address < cfg_i.base_address);
    sts_o.div_done   = div_done;
    sts_o.q_past_end = (quo >= 64'(total));
    sts_o.scan_hit   = !cur_bit && (32'(run_q) + 32'd1 == 32'(req_q.count));
    sts_o.scan_last  = (32'(i_q) + 32'd1 == tot32);
    sts_o.mark_last  = (w_q == we);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clear_map_i) begin
        vld_q <= '0;
      end else if (cmd_i.mark_step) begin
        vld_q[w_q] <= 1'b1;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_req_i;
      i_q   <= '0;
      run_q <= '0;
    end
    if (cmd_i.scan_step) begin
      i_q   <= i_q + 1'b1;
      run_q <= cur_bit ? '0 : run_q + 1'b1;
    end
    if (cmd_i.free_setup || (cmd_i.scan_step && sts_o.scan_hit)) begin
      start_q <= set_start;
      last_q  <= set_last;
      w_q     <= AW'(set_start / WORD_BITS);
    end
    if (cmd_i.mark_step) begin
      mem_q[w_q] <= new_word;
      w_q        <= w_q + 1'b1;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(start_q) * PW'(cfg_i.item_size);
    end
    if (cmd_i.res_load) begin
      case (cmd_i.res_kind)
        RES_BASE: rsp_q <= '{ok: 1'b1, address: cfg_i.base_address};
        RES_ZERO: rsp_q <= '{ok: 1'b1, address: '0};
        RES_ADDR: rsp_q <= '{ok: 1'b1, address: cfg_i.base_address + ADDR_W'(prod_q)};
        default:  rsp_q <= '{ok: 1'b0, address: '0};
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

### src/bra_ctrl.sv
// Request sequencer of the allocator.
module bra_ctrl import bra_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

`include "assert_macros.svh"

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHECK = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_SCAN  = 7'b0001000,
    ST_MARK  = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e    state_q, state_d;
  res_kind_e kind_q, kind_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = '0;
    cmd_o.res_kind = kind_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = ST_DONE;
        if (sts_i.is_free) begin
          if (sts_i.count_zero || sts_i.below_base) begin
            kind_d = RES_FAIL;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV;
          end
        end else if (sts_i.total_zero) begin
          kind_d = RES_FAIL;
        end else if (sts_i.count_zero) begin
          kind_d = RES_BASE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.free_setup = 1'b1;
          if (sts_i.q_past_end) begin
            kind_d  = RES_ZERO;
            state_d = ST_DONE;
          end else begin
            state_d = ST_MARK;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = ST_MARK;
        end else if (sts_i.scan_last) begin
          kind_d  = RES_FAIL;
          state_d = ST_DONE;
        end
      end
      ST_MARK: begin
        cmd_o.mark_step = 1'b1;
        if (sts_i.mark_last) begin
          if (sts_i.is_free) begin
            kind_d  = RES_ZERO;
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        kind_d    = RES_ADDR;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= RES_FAIL;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  `BRA_ASSERT_IMP(a_res_slot_free, clk_i, rst_ni, cmd_o.res_load, sts_i.out_free)
  `BRA_ASSERT_IMP(a_scan_alloc_only, clk_i, rst_ni, cmd_o.scan_step, !sts_i.is_free)
  `BRA_ASSERT(a_mark_ends, clk_i, rst_ni,
              (cmd_o.mark_step && sts_i.mark_last) |=> (state_q != ST_MARK))

endmodule
